@@ hw/rtl/iols_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iols_pkg
// Shared constants and types for the indexed ordered list store: field
// widths, operation codes, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package iols_pkg;

  // Payload field widths
  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE     = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND       = 3'd4;
  localparam logic [OP_W-1:0] OP_READ       = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_LAST,
    S_FILL,
    S_DN_RD,
    S_DN_LAST,
    S_FIND,
    S_RD_ISSUE,
    S_RD_CAP,
    S_RESP
  } state_t;

endpackage

@@ hw/rtl/iols_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iols_if
// Valid/ready channels of the list store: the command channel that carries
// one operation and the response channel that carries its result.
// ----------------------------------------------------------------------------
interface iols_cmd_if;
  logic                                valid;
  logic                                ready;
  logic        [iols_pkg::OP_W-1:0]    op;
  logic signed [iols_pkg::VAL_W-1:0]   item_value;
  logic        [iols_pkg::POS_W-1:0]   position;

  modport source (output valid, output op, output item_value, output position,
                  input ready);
  modport sink   (input valid, input op, input item_value, input position,
                  output ready);
endinterface

interface iols_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [iols_pkg::STAT_W-1:0]  status;
  logic        [iols_pkg::POS_W-1:0]   found_position;
  logic signed [iols_pkg::VAL_W-1:0]   read_value;
  logic        [iols_pkg::CNT_W-1:0]   entry_count;

  modport source (output valid, output status, output found_position,
                  output read_value, output entry_count, input ready);
  modport sink   (input valid, input status, input found_position,
                  input read_value, input entry_count, output ready);
endinterface

@@ hw/rtl/iols_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iols_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module iols_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [WIDTH-1:0]              wdata,
  input  logic                          re,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/indexed_ordered_list_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_ordered_list_store
// Ordered list of up to CAPACITY signed 32-bit values held in one RAM, with
// append, insert before/after, delete, find, read and clear operations.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  --------+-----+-------------------------------------------------------
//  cmd     | in  | op, item_value, position
//  rsp     | out | status, found_position, read_value, entry_count
//
//  One command at a time; cmd.ready is high only while the sequencer idles.
//  Insert moves the elements from the gap to the tail up one place unless
//  it lands after the tail; delete moves the later elements down unless it
//  takes the tail; find stops at the first match. Element moves and
//  compares go through the single RAM read port, one element per cycle.
//  Synchronous reset empties the list; RAM contents are not cleared.
//  A response waits in its output register while rsp.ready is low; the
//  next command is still taken, and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module indexed_ordered_list_store #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  iols_cmd_if.sink   cmd,
  iols_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = (CW > iols_pkg::POS_W) ? CW : iols_pkg::POS_W;

  // Control registers
  iols_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] cur, cur_next;
  logic [IW-1:0] at, at_next;
  logic          pend, pend_next;
  logic [IW-1:0] pend_addr, pend_addr_next;
  logic          cmp_valid, cmp_valid_next;
  logic [CW-1:0] cmp_idx, cmp_idx_next;
  logic          rsp_valid, rsp_valid_next;

  // Payload registers
  logic [iols_pkg::VAL_W-1:0]  val, val_next;
  logic [iols_pkg::STAT_W-1:0] res_status, res_status_next;
  logic [iols_pkg::POS_W-1:0]  res_found, res_found_next;
  logic [iols_pkg::VAL_W-1:0]  res_rd, res_rd_next;
  logic [iols_pkg::STAT_W-1:0] out_status, out_status_next;
  logic [iols_pkg::POS_W-1:0]  out_found, out_found_next;
  logic [iols_pkg::VAL_W-1:0]  out_rd, out_rd_next;
  logic [iols_pkg::CNT_W-1:0]  out_count, out_count_next;

  // RAM port
  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  logic [iols_pkg::VAL_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [IW-1:0]              ram_raddr;
  logic [iols_pkg::VAL_W-1:0] ram_rdata;

  iols_ram #(
    .WIDTH (iols_pkg::VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: decode, element moves, search and response handoff
  always_comb begin
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] at_x;
    logic          full;
    logic          bad;
    logic          issue;

    pos_x = XW'(cmd.position);
    cnt_x = XW'(count);
    full  = (count == CW'(CAPACITY));
    bad   = (pos_x >= cnt_x);
    at_x  = pos_x;
    issue = (cur < count);

    state_next      = state;
    count_next      = count;
    cur_next        = cur;
    at_next         = at;
    pend_next       = 1'b0;
    pend_addr_next  = pend_addr;
    cmp_valid_next  = cmp_valid;
    cmp_idx_next    = cmp_idx;
    val_next        = val;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_rd_next     = res_rd;
    out_status_next = out_status;
    out_found_next  = out_found;
    out_rd_next     = out_rd;
    out_count_next  = out_count;
    rsp_valid_next  = rsp_valid && !rsp.ready;

    // Pending write of an element read in the previous cycle
    ram_we    = pend;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = cur[IW-1:0];

    unique case (state)
      iols_pkg::S_IDLE: begin
        if (cmd.valid) begin
          val_next        = cmd.item_value;
          res_status_next = iols_pkg::ST_OK;
          res_found_next  = '0;
          res_rd_next     = '0;
          state_next      = iols_pkg::S_RESP;
          unique case (cmd.op) inside
            iols_pkg::OP_APPEND: begin
              if (full) begin
                res_status_next = iols_pkg::ST_FULL;
              end else begin
                at_next    = IW'(count);
                state_next = iols_pkg::S_FILL;
              end
            end
            iols_pkg::OP_INS_BEFORE, iols_pkg::OP_INS_AFTER: begin
              if (cmd.op == iols_pkg::OP_INS_AFTER) begin
                at_x = pos_x + XW'(1);
              end
              if (full) begin
                res_status_next = iols_pkg::ST_FULL;
              end else if (bad) begin
                res_status_next = iols_pkg::ST_RANGE;
              end else begin
                at_next = IW'(at_x);
                if (at_x == cnt_x) begin
                  state_next = iols_pkg::S_FILL;
                end else begin
                  cur_next   = count - CW'(1);
                  state_next = iols_pkg::S_UP_RD;
                end
              end
            end
            iols_pkg::OP_DELETE: begin
              if (bad) begin
                res_status_next = iols_pkg::ST_RANGE;
              end else if (pos_x == cnt_x - XW'(1)) begin
                count_next = count - CW'(1);
              end else begin
                cur_next   = CW'(pos_x + XW'(1));
                state_next = iols_pkg::S_DN_RD;
              end
            end
            iols_pkg::OP_FIND: begin
              cur_next       = '0;
              cmp_valid_next = 1'b0;
              state_next     = iols_pkg::S_FIND;
            end
            iols_pkg::OP_READ: begin
              if (bad) begin
                res_status_next = iols_pkg::ST_RANGE;
              end else begin
                at_next    = IW'(pos_x);
                state_next = iols_pkg::S_RD_ISSUE;
              end
            end
            iols_pkg::OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Shift elements up one place, from the tail down to the gap
      iols_pkg::S_UP_RD: begin
        ram_re         = 1'b1;
        pend_next      = 1'b1;
        pend_addr_next = cur[IW-1:0] + IW'(1);
        if (cur == CW'(at)) begin
          state_next = iols_pkg::S_UP_LAST;
        end else begin
          cur_next = cur - CW'(1);
        end
      end
      iols_pkg::S_UP_LAST: begin
        state_next = iols_pkg::S_FILL;
      end
      iols_pkg::S_FILL: begin
        ram_we     = 1'b1;
        ram_waddr  = at;
        ram_wdata  = val;
        count_next = count + CW'(1);
        state_next = iols_pkg::S_RESP;
      end

      // Shift elements down one place, closing the gap toward the tail
      iols_pkg::S_DN_RD: begin
        ram_re         = 1'b1;
        pend_next      = 1'b1;
        pend_addr_next = cur[IW-1:0] - IW'(1);
        if (cur == count - CW'(1)) begin
          state_next = iols_pkg::S_DN_LAST;
        end else begin
          cur_next = cur + CW'(1);
        end
      end
      iols_pkg::S_DN_LAST: begin
        count_next = count - CW'(1);
        state_next = iols_pkg::S_RESP;
      end

      // Walk from the head, compare each element in the cycle after its read
      iols_pkg::S_FIND: begin
        ram_re         = issue;
        cmp_valid_next = issue;
        cmp_idx_next   = cur;
        if (issue) begin
          cur_next = cur + CW'(1);
        end
        if (cmp_valid && (ram_rdata == val)) begin
          res_status_next = iols_pkg::ST_OK;
          res_found_next  = iols_pkg::POS_W'(cmp_idx);
          cmp_valid_next  = 1'b0;
          state_next      = iols_pkg::S_RESP;
        end else if (!issue && !cmp_valid) begin
          res_status_next = iols_pkg::ST_MISSING;
          state_next      = iols_pkg::S_RESP;
        end
      end

      iols_pkg::S_RD_ISSUE: begin
        ram_re     = 1'b1;
        ram_raddr  = at;
        state_next = iols_pkg::S_RD_CAP;
      end
      iols_pkg::S_RD_CAP: begin
        res_rd_next = ram_rdata;
        state_next  = iols_pkg::S_RESP;
      end

      // Hand the result to the output register once it is free
      iols_pkg::S_RESP: begin
        if (!rsp_valid || rsp.ready) begin
          out_status_next = res_status;
          out_found_next  = res_found;
          out_rd_next     = res_rd;
          out_count_next  = iols_pkg::CNT_W'(count);
          rsp_valid_next  = 1'b1;
          state_next      = iols_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = iols_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= iols_pkg::S_IDLE;
      count     <= '0;
      cur       <= '0;
      at        <= '0;
      pend      <= 1'b0;
      pend_addr <= '0;
      cmp_valid <= 1'b0;
      cmp_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cur       <= cur_next;
      at        <= at_next;
      pend      <= pend_next;
      pend_addr <= pend_addr_next;
      cmp_valid <= cmp_valid_next;
      cmp_idx   <= cmp_idx_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    val        <= val_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_rd     <= res_rd_next;
    out_status <= out_status_next;
    out_found  <= out_found_next;
    out_rd     <= out_rd_next;
    out_count  <= out_count_next;
  end

  assign cmd.ready          = (state == iols_pkg::S_IDLE);
  assign rsp.valid          = rsp_valid;
  assign rsp.status         = out_status;
  assign rsp.found_position = out_found;
  assign rsp.read_value     = out_rd;
  assign rsp.entry_count    = out_count;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_rsp_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == iols_pkg::S_RESP)
    else $error("response loaded outside the handoff state");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == iols_pkg::S_IDLE) |-> !ram_we)
    else $error("store written while idle");

  a_find_no_move: assert property (@(posedge clk) disable iff (rst)
    (state == iols_pkg::S_FIND) |-> !ram_we)
    else $error("store written during a search");

endmodule

@@ test/list_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_check_pkg
// Shadow list and scoreboard for the indexed ordered list store bench. Each
// accepted command updates a private copy of the list and queues the response
// it must produce. Each accepted response is checked field by field against
// the oldest queued one.
// ----------------------------------------------------------------------------
package list_check_pkg;
  import iols_pkg::*;

  localparam int CAPACITY = 16;

  // Opcode the block treats as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic        [STAT_W-1:0] status;
    logic        [POS_W-1:0]  found_position;
    logic signed [VAL_W-1:0]  read_value;
    logic        [CNT_W-1:0]  entry_count;
  } list_result_t;

  class list_scoreboard;
    logic signed [VAL_W-1:0] elems [CAPACITY];
    int                      length;
    list_result_t            pending_q [$];
    int                      errors;
    int                      checked;

    function new();
      length  = 0;
      errors  = 0;
      checked = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Shift the tail up by one and drop the value into the gap
    function void open_gap(int at, logic signed [VAL_W-1:0] v);
      for (int k = length; k > at; k--) begin
        elems[k] = elems[k-1];
      end
      elems[at] = v;
      length++;
    endfunction

    // Apply one accepted command to the shadow list and queue its response
    function void note_command(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v,
                               logic [POS_W-1:0] pos);
      list_result_t r;
      int           p;
      r = '0;
      p = int'(pos);
      case (op)
        OP_APPEND: begin
          if (length >= CAPACITY) r.status = ST_FULL;
          else open_gap(length, v);
        end
        OP_INS_BEFORE, OP_INS_AFTER: begin
          if (length >= CAPACITY) r.status = ST_FULL;
          else if (p >= length) r.status = ST_RANGE;
          else open_gap((op == OP_INS_BEFORE) ? p : p + 1, v);
        end
        OP_DELETE: begin
          if (p >= length) begin
            r.status = ST_RANGE;
          end else begin
            for (int k = p; k + 1 < length; k++) elems[k] = elems[k+1];
            length--;
          end
        end
        OP_FIND: begin
          r.status = ST_MISSING;
          for (int k = 0; k < length; k++) begin
            if (r.status == ST_MISSING && elems[k] == v) begin
              r.status         = ST_OK;
              r.found_position = k[POS_W-1:0];
            end
          end
        end
        OP_READ: begin
          if (p >= length) r.status = ST_RANGE;
          else r.read_value = elems[p];
        end
        OP_CLEAR: length = 0;
        default: ;
      endcase
      r.entry_count = length[CNT_W-1:0];
      pending_q.push_back(r);
    endfunction

    task report(string field, longint want, longint got);
      $display("response %0d: %s expected %0d, got %0d", checked, field, want, got);
      errors++;
    endtask

    // Compare one accepted response with the oldest pending one
    task check_result(list_result_t got);
      list_result_t want;
      if (pending_q.size() == 0) begin
        report("unexpected response, status", -1, got.status);
      end else begin
        want = pending_q.pop_front();
        if (got.status !== want.status)
          report("status", want.status, got.status);
        if (got.found_position !== want.found_position)
          report("found_position", want.found_position, got.found_position);
        if (got.read_value !== want.read_value)
          report("read_value", want.read_value, got.read_value);
        if (got.entry_count !== want.entry_count)
          report("entry_count", want.entry_count, got.entry_count);
      end
      checked++;
    endtask
  endclass

endpackage

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the indexed ordered list store. A directed opening hits empty
// and out-of-range cases, the value extremes, index zero inserts and the
// unused opcode; random traffic then cycles through grow, mixed and shrink
// phases so the list runs full and empty many times. Both channels idle at
// random, with quiet stretches of back-to-back transfers.
// ----------------------------------------------------------------------------
module tb_top;
  import iols_pkg::*;
  import list_check_pkg::*;

  localparam int N_RANDOM   = 1400;
  localparam int STALL_MAX  = 1000;
  localparam int DRAIN_WAIT = CAPACITY + 8;

  logic clk;
  logic rst;
  bit   no_idle;
  int   stall_cycles;

  list_scoreboard sb;

  iols_cmd_if cmd_ch ();
  iols_rsp_if rsp_ch ();

  indexed_ordered_list_store #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Check responses before noting commands seen at the same edge
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_result('{rsp_ch.status, rsp_ch.found_position, rsp_ch.read_value,
                        rsp_ch.entry_count});
    end
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      sb.note_command(cmd_ch.op, cmd_ch.item_value, cmd_ch.position);
    end
  end

  // Watchdog: abort when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Drive one command; called and returns at a falling edge
  task automatic send_command(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v,
                              logic [POS_W-1:0] pos);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.op         <= op;
    cmd_ch.item_value <= v;
    cmd_ch.position   <= pos;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  // Response side: stall a random number of cycles per transfer
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  function automatic logic [OP_W-1:0] pick_op(int phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      // grow
      0: begin
        if (r < 35) return OP_APPEND;
        if (r < 55) return OP_INS_BEFORE;
        if (r < 75) return OP_INS_AFTER;
        if (r < 83) return OP_READ;
        if (r < 91) return OP_FIND;
        if (r < 97) return OP_DELETE;
        if (r < 99) return OP_UNUSED;
        return OP_CLEAR;
      end
      // shrink
      2: begin
        if (r < 45) return OP_DELETE;
        if (r < 60) return OP_READ;
        if (r < 75) return OP_FIND;
        if (r < 85) return OP_APPEND;
        if (r < 90) return OP_INS_BEFORE;
        if (r < 95) return OP_INS_AFTER;
        if (r < 98) return OP_UNUSED;
        return OP_CLEAR;
      end
      // mixed
      default: begin
        if (r < 16) return OP_APPEND;
        if (r < 30) return OP_INS_BEFORE;
        if (r < 44) return OP_INS_AFTER;
        if (r < 60) return OP_DELETE;
        if (r < 76) return OP_FIND;
        if (r < 92) return OP_READ;
        if (r < 96) return OP_UNUSED;
        return OP_CLEAR;
      end
    endcase
  endfunction

  // Favor values already stored when searching; mix in the extremes
  function automatic logic signed [VAL_W-1:0] pick_value(bit searching);
    int r;
    r = $urandom_range(0, 99);
    if (searching && sb.length > 0 && r < 60)
      return sb.elems[$urandom_range(0, sb.length - 1)];
    if (r >= 90) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fff_ffff;
        1: return 32'sh8000_0000;
        2: return 32'sh0000_0000;
        default: return 32'shffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // Mostly valid indexes, some anywhere in the field
  function automatic logic [POS_W-1:0] pick_position();
    if (sb.length > 0 && $urandom_range(0, 99) < 85)
      return POS_W'($urandom_range(0, sb.length - 1));
    return POS_W'($urandom_range(0, 15));
  endfunction

  initial begin
    logic [OP_W-1:0] op;
    sb                = new();
    no_idle           = 1'b0;
    rst               = 1'b1;
    cmd_ch.valid      = 1'b0;
    cmd_ch.op         = OP_APPEND;
    cmd_ch.item_value = '0;
    cmd_ch.position   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty list: every indexed operation and find must fail
    send_command(OP_FIND, 32'sd5, 4'd0);
    send_command(OP_READ, 32'sd0, 4'd0);
    send_command(OP_INS_BEFORE, 32'sd1, 4'd0);
    send_command(OP_INS_AFTER, 32'sd1, 4'd0);
    send_command(OP_DELETE, 32'sd0, 4'd0);
    // Extremes, then inserts around index zero and after the last entry
    send_command(OP_APPEND, 32'sh7fff_ffff, 4'd15);
    send_command(OP_APPEND, 32'sh8000_0000, 4'd0);
    send_command(OP_INS_BEFORE, 32'sd1, 4'd0);
    send_command(OP_INS_AFTER, -32'sd1, 4'd0);
    send_command(OP_INS_AFTER, 32'shaaaa_aaaa, 4'd3);
    send_command(OP_INS_BEFORE, 32'sh5555_5555, 4'd15);
    send_command(OP_READ, 32'sd0, 4'd15);
    send_command(OP_READ, 32'sd0, 4'd4);
    send_command(OP_FIND, 32'sh8000_0000, 4'd0);
    send_command(OP_FIND, 32'sd12345, 4'd0);
    send_command(OP_UNUSED, 32'shffff_ffff, 4'd15);
    send_command(OP_DELETE, 32'sd0, 4'd4);
    send_command(OP_DELETE, 32'sd0, 4'd0);
    send_command(OP_READ, 32'sd0, 4'd0);
    send_command(OP_CLEAR, 32'sd0, 4'd0);
    send_command(OP_READ, 32'sd0, 4'd0);
    send_command(OP_FIND, 32'sd1, 4'd0);
    send_command(OP_APPEND, 32'sh5555_5555, 4'd0);

    // Random phases: grow, mixed, shrink, mixed
    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = ((i / 150) % 4) == 3;
      // hold off once until the list store has answered everything
      if (i == N_RANDOM / 2) begin
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      op = pick_op((i / 40) % 4);
      send_command(op, pick_value(op == OP_FIND), pick_position());
    end
    cmd_ch.valid <= 1'b0;

    // Drain and let any stray response show up
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
